@@ hdl/plrq_pkg.sv @@
// Shared types and constants for the positional list with run query.
// Holds request, error and command codes, and the cell command and scan word layouts.
// No dependencies.
package plrq_pkg;

  localparam int unsigned CAP_DEFAULT = 64;
  localparam int unsigned CAP_MAX     = 1024;
  localparam int unsigned CNT_W       = $clog2(CAP_MAX + 1);
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned ERR_W       = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_REMOVE  = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_READ    = 3'd4,
    REQ_CLEAR   = 3'd5,
    REQ_RUN     = 3'd6,
    REQ_NOP     = 3'd7
  } req_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic [CNT_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
  } cmd_t;

  typedef struct packed {
    logic                     valid;
    logic [CNT_W-1:0]         cur_start;
    logic [CNT_W-1:0]         cur_len;
    logic [CNT_W-1:0]         best_len;
    logic [CNT_W-1:0]         best_start;
    logic signed [DATA_W-1:0] rd;
  } scan_t;

endpackage

@@ hdl/positional_list_with_run_query.sv @@
// Positional list with longest-run query: top level.
// Ties the controller to a chain of CAPACITY list cells.
// Depends on plrq_pkg, plrq_ctrl, plrq_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request word: req_type_i,
//   value_i, position_i. Output channel (out_valid_o/out_ready_i) returns one
//   result word per request: read_value_o, run_start_o, count_o, is_empty_o,
//   is_full_o, error_o.
//   Append, insert, remove, replace, clear, code 7 and every rejected request
//   finish without a scan: the result is valid the cycle after acceptance, and a
//   new request is taken each cycle while the result is drained.
//   Read and run query pass a scan word through every cell, one cell a cycle:
//   the result is valid once the word leaves the last cell and is registered,
//   and no request is taken meanwhile. The length of the cell chain sets the wait.
//   A request is taken only when the output register is empty or drains in the
//   same cycle; a stalled receiver holds the result and blocks new requests.
//   Reset empties the list; element storage is not cleared.
module positional_list_with_run_query import plrq_pkg::*; #(
  parameter int unsigned CAPACITY = CAP_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [POS_W-1:0]         run_start_o,
  output logic [POS_W-1:0]         count_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [ERR_W-1:0]         error_o
);

  cmd_t                     cmd;
  scan_t                    scan_w [CAPACITY+1];
  logic signed [DATA_W-1:0] elem_w [CAPACITY];

  plrq_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .read_value_o(read_value_o),
    .run_start_o (run_start_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o),
    .is_full_o   (is_full_o),
    .error_o     (error_o),
    .cmd_o       (cmd),
    .scan_o      (scan_w[0]),
    .scan_i      (scan_w[CAPACITY])
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plrq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (CNT_W'(i)),
      .cmd_i       (cmd),
      .left_elem_i ((i == 0) ? elem_w[i] : elem_w[(i == 0) ? 0 : i-1]),
      .right_elem_i((i == CAPACITY-1) ? elem_w[i] : elem_w[(i == CAPACITY-1) ? i : i+1]),
      .elem_o      (elem_w[i]),
      .scan_i      (scan_w[i]),
      .scan_o      (scan_w[i+1])
    );
  end

endmodule

@@ hdl/plrq_cell.sv @@
// One list cell: holds one element, shifts with its neighbors on insert and remove,
// and advances the scan word one step for reads and run queries.
// Depends on plrq_pkg.
module plrq_cell import plrq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CNT_W-1:0]         idx_i,
  input  cmd_t                     cmd_i,
  input  logic signed [DATA_W-1:0] left_elem_i,
  input  logic signed [DATA_W-1:0] right_elem_i,
  output logic signed [DATA_W-1:0] elem_o,
  input  scan_t                    scan_i,
  output scan_t                    scan_o
);

  logic signed [DATA_W-1:0] elem_q, elem_d;
  scan_t                    scan_q, scan_d;
  logic                     run_on;

  always_comb begin
    elem_d = elem_q;
    case (cmd_i.op)
      CMD_WRITE: begin
        if (idx_i == cmd_i.pos) elem_d = cmd_i.value;
      end
      CMD_INSERT: begin
        if (idx_i > cmd_i.pos) begin
          elem_d = left_elem_i;
        end else if (idx_i == cmd_i.pos) begin
          elem_d = cmd_i.value;
        end
      end
      CMD_REMOVE: begin
        if (idx_i >= cmd_i.pos) elem_d = right_elem_i;
      end
      default: elem_d = elem_q;
    endcase
  end

  always_comb begin
    scan_d = scan_i;
    run_on = (idx_i != '0) && (idx_i < cmd_i.count);
    if (scan_i.valid) begin
      if (run_on) begin
        if (elem_q == left_elem_i) begin
          scan_d.cur_len = scan_i.cur_len + 1'b1;
        end else begin
          scan_d.cur_start = idx_i;
          scan_d.cur_len   = CNT_W'(1);
        end
        if ((scan_d.cur_len >= CNT_W'(2)) && (scan_d.cur_len > scan_i.best_len)) begin
          scan_d.best_len   = scan_d.cur_len;
          scan_d.best_start = scan_d.cur_start;
        end
      end
      if (idx_i == cmd_i.pos) scan_d.rd = elem_q;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign elem_o = elem_q;
  assign scan_o = scan_q;

endmodule

@@ hdl/plrq_ctrl.sv @@
// Request decoder, element count, scan sequencing and output register.
// Drives the cell command and injects scan words at the head of the cell chain.
// Depends on plrq_pkg.
module plrq_ctrl import plrq_pkg::*; #(
  parameter int unsigned CAPACITY = CAP_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [POS_W-1:0]         run_start_o,
  output logic [POS_W-1:0]         count_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [ERR_W-1:0]         error_o,
  output cmd_t                     cmd_o,
  output scan_t                    scan_o,
  input  scan_t                    scan_i
);

  localparam logic [CNT_W-1:0] Cap = CNT_W'(CAPACITY);

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         pos_q;
  logic                     run_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] read_value_q;
  logic [POS_W-1:0]         run_start_q;
  err_e                     err_q, err_d;

  logic             accept, full, start_scan, scan_run, load_now, scan_done;
  logic [CNT_W-1:0] pos_ext;
  cmd_op_e          op_d;
  logic [CNT_W-1:0] cmd_pos;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (count_q >= Cap);
  assign pos_ext    = CNT_W'(position_i);

  always_comb begin
    op_d       = CMD_NONE;
    cmd_pos    = pos_q;
    count_d    = count_q;
    err_d      = ERR_OK;
    start_scan = 1'b0;
    scan_run   = 1'b0;
    if (accept) begin
      cmd_pos = pos_ext;
      case (req_e'(req_type_i))
        REQ_APPEND: begin
          if (full) begin
            err_d = ERR_FULL;
          end else begin
            op_d    = CMD_WRITE;
            cmd_pos = count_q;
            count_d = count_q + 1'b1;
          end
        end
        REQ_INSERT: begin
          if (full) begin
            err_d = ERR_FULL;
          end else if (pos_ext > count_q) begin
            err_d = ERR_RANGE;
          end else begin
            op_d    = CMD_INSERT;
            count_d = count_q + 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (pos_ext >= count_q) begin
            err_d = ERR_RANGE;
          end else begin
            op_d    = CMD_REMOVE;
            count_d = count_q - 1'b1;
          end
        end
        REQ_REPLACE: begin
          if (pos_ext >= count_q) begin
            err_d = ERR_RANGE;
          end else begin
            op_d = CMD_WRITE;
          end
        end
        REQ_READ: begin
          if (pos_ext >= count_q) begin
            err_d = ERR_RANGE;
          end else begin
            start_scan = 1'b1;
          end
        end
        REQ_CLEAR: begin
          count_d = '0;
        end
        REQ_RUN: begin
          start_scan = 1'b1;
          scan_run   = 1'b1;
        end
        default: begin
          op_d = CMD_NONE;
        end
      endcase
    end
  end

  assign load_now  = accept && !start_scan;
  assign scan_done = (state_q == ST_SCAN) && scan_i.valid;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_scan) state_d = ST_SCAN;
      ST_SCAN: if (scan_done) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o.op    = op_d;
  assign cmd_o.pos   = cmd_pos;
  assign cmd_o.value = value_i;
  assign cmd_o.count = count_q;

  always_comb begin
    scan_o            = '0;
    scan_o.valid      = start_scan;
    scan_o.cur_len    = CNT_W'(1);
    scan_o.best_len   = CNT_W'(1);
    scan_o.best_start = count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load_now || scan_done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= pos_ext;
      run_q <= scan_run;
    end
    if (load_now) begin
      read_value_q <= '0;
      run_start_q  <= '0;
      err_q        <= err_d;
    end else if (scan_done) begin
      read_value_q <= run_q ? '0 : scan_i.rd;
      run_start_q  <= run_q ? scan_i.best_start[POS_W-1:0] : '0;
      err_q        <= ERR_OK;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign run_start_o  = run_start_q;
  assign count_o      = count_q[POS_W-1:0];
  assign is_empty_o   = (count_q == '0);
  assign is_full_o    = (count_q == Cap);
  assign error_o      = err_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cap)
    else $error("element count above capacity");

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_i.valid |-> state_q == ST_SCAN)
    else $error("scan word left the chain outside a scan");

  a_scan_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> !out_valid_q)
    else $error("output word pending during a scan");

  a_cmd_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op != CMD_NONE |-> accept && !start_scan)
    else $error("cell command without an accepted request");

endmodule

@@ bench/plrq_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the positional list: predicts each result word from accepted requests.
// Compares returned words field by field; depends on plrq_pkg.
module plrq_checker import plrq_pkg::*; #(
  parameter int unsigned CAPACITY = CAP_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [DATA_W-1:0] read_value_i,
  input  logic [POS_W-1:0]         run_start_i,
  input  logic [POS_W-1:0]         count_i,
  input  logic                     is_empty_i,
  input  logic                     is_full_i,
  input  logic [ERR_W-1:0]         error_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  typedef struct packed {
    logic signed [DATA_W-1:0] rd;
    logic [POS_W-1:0]         run;
    logic [POS_W-1:0]         cnt;
    logic                     empty;
    logic                     full;
    err_e                     err;
  } list_reply_t;

  logic signed [DATA_W-1:0] elems [CAPACITY];
  int                       n_elems = 0;
  int                       fails = 0;
  list_reply_t              predicted_words [$];

  function automatic list_reply_t list_apply(logic [REQ_W-1:0] code,
                                             logic signed [DATA_W-1:0] val,
                                             logic [POS_W-1:0] pos);
    list_reply_t r;
    int          i;
    int          best_len;
    int          best_start;
    int          cur_start;
    int          cur_len;
    r     = '0;
    r.err = ERR_OK;
    case (code)
      REQ_APPEND: begin
        if (n_elems >= CAPACITY) begin
          r.err = ERR_FULL;
        end else begin
          elems[n_elems] = val;
          n_elems++;
        end
      end
      REQ_INSERT: begin
        if (n_elems >= CAPACITY) begin
          r.err = ERR_FULL;
        end else if (int'(pos) > n_elems) begin
          r.err = ERR_RANGE;
        end else begin
          for (i = n_elems; i > int'(pos); i--) elems[i] = elems[i-1];
          elems[pos] = val;
          n_elems++;
        end
      end
      REQ_REMOVE: begin
        if (int'(pos) >= n_elems) begin
          r.err = ERR_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < n_elems; i++) elems[i] = elems[i+1];
          n_elems--;
        end
      end
      REQ_REPLACE: begin
        if (int'(pos) >= n_elems) r.err = ERR_RANGE;
        else elems[pos] = val;
      end
      REQ_READ: begin
        if (int'(pos) >= n_elems) r.err = ERR_RANGE;
        else r.rd = elems[pos];
      end
      REQ_CLEAR: begin
        n_elems = 0;
      end
      REQ_RUN: begin
        best_len   = 1;
        best_start = n_elems;
        cur_start  = 0;
        cur_len    = 1;
        for (i = 1; i < n_elems; i++) begin
          if (elems[i] == elems[i-1]) begin
            cur_len++;
          end else begin
            cur_start = i;
            cur_len   = 1;
          end
          if (cur_len >= 2 && cur_len > best_len) begin
            best_len   = cur_len;
            best_start = cur_start;
          end
        end
        r.run = best_start[POS_W-1:0];
      end
      default: ;
    endcase
    r.cnt   = n_elems[POS_W-1:0];
    r.empty = (n_elems == 0);
    r.full  = (n_elems == CAPACITY);
    return r;
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    list_reply_t want;
    if (!rst_ni) begin
      n_elems = 0;
      predicted_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: result word with nothing expected, count %0d error %0d",
                   $time, count_i, error_i);
          fails++;
        end else begin
          want = predicted_words.pop_front();
          check_field("read_value", want.rd, read_value_i);
          check_field("run_start", 32'(want.run), 32'(run_start_i));
          check_field("count", 32'(want.cnt), 32'(count_i));
          check_field("is_empty", 32'(want.empty), 32'(is_empty_i));
          check_field("is_full", 32'(want.full), 32'(is_full_i));
          check_field("error", 32'(want.err), 32'(error_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predicted_words.push_back(list_apply(req_type_i, value_i, position_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= predicted_words.size();
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top of the positional list bench: clock, reset, request stimulus and verdict.
// Depends on plrq_pkg, positional_list_with_run_query and plrq_checker.
module testbench;
  import plrq_pkg::*;

  localparam int unsigned CAPACITY = CAP_DEFAULT;
  localparam int          N_RANDOM = 800;
  localparam int          LIMIT    = 400000;
  localparam int          LONG_HOLD = 300;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [REQ_W-1:0]         req_type_i;
  logic signed [DATA_W-1:0] value_i;
  logic [POS_W-1:0]         position_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] read_value_o;
  logic [POS_W-1:0]         run_start_o;
  logic [POS_W-1:0]         count_o;
  logic                     is_empty_o;
  logic                     is_full_o;
  logic [ERR_W-1:0]         error_o;

  int fail_count;
  int pending;
  int tx_idle_pct = 8;
  int rx_idle_pct = 52;
  bit hold_go = 1'b0;
  int cycles = 0;
  int shadow_len = 0;
  int peak_len = 0;
  int full_adds = 0;
  int sent_by_kind [8];

  positional_list_with_run_query #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .value_i, .position_i,
    .out_valid_o, .out_ready_i, .read_value_o, .run_start_o, .count_o,
    .is_empty_o, .is_full_o, .error_o
  );

  plrq_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .value_i,
    .position_i, .out_valid_i(out_valid_o), .out_ready_i, .read_value_i(read_value_o),
    .run_start_i(run_start_o), .count_i(count_o), .is_empty_i(is_empty_o),
    .is_full_i(is_full_o), .error_i(error_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : receiver
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (hold_go) begin
        hold_go     = 1'b0;
        hold_left   = LONG_HOLD;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  task automatic offer_request(req_e kind, logic signed [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while ($urandom_range(99, 0) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    sent_by_kind[kind]++;
    case (kind)
      REQ_APPEND: begin
        if (shadow_len >= CAPACITY) full_adds++;
        else shadow_len++;
      end
      REQ_INSERT: begin
        if (shadow_len >= CAPACITY) full_adds++;
        else if (int'(pos) <= shadow_len) shadow_len++;
      end
      REQ_REMOVE: if (int'(pos) < shadow_len) shadow_len--;
      REQ_CLEAR:  shadow_len = 0;
      default: ;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    int                       roll;
    int                       mode;
    req_e                     kind;
    logic signed [DATA_W-1:0] val;
    logic [POS_W-1:0]         pos;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_NOP;
    value_i    = '0;
    position_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases, starting from the empty list
    offer_request(REQ_RUN, 32'sd0, 7'd0);
    offer_request(REQ_READ, 32'sd0, 7'd0);
    offer_request(REQ_REMOVE, 32'sd0, 7'd0);
    offer_request(REQ_INSERT, 32'sd5, 7'd1);
    offer_request(REQ_APPEND, 32'sh7fffffff, 7'd0);
    offer_request(REQ_RUN, 32'sd0, 7'd0);
    offer_request(REQ_APPEND, 32'sh80000000, 7'd0);
    offer_request(REQ_INSERT, -32'sd1, 7'd0);
    offer_request(REQ_INSERT, 32'sd0, 7'd3);
    offer_request(REQ_INSERT, 32'sd9, 7'd127);
    offer_request(REQ_REPLACE, -32'sd1, 7'd2);
    offer_request(REQ_REPLACE, 32'sd3, 7'd64);
    offer_request(REQ_APPEND, 32'sd5, 7'd0);
    offer_request(REQ_APPEND, 32'sd5, 7'd0);
    offer_request(REQ_APPEND, 32'sd5, 7'd0);
    offer_request(REQ_RUN, 32'sd0, 7'd0);
    offer_request(REQ_READ, 32'sd0, 7'd0);
    offer_request(REQ_READ, 32'sd0, 7'd6);
    offer_request(REQ_READ, 32'sd0, 7'd127);
    offer_request(REQ_REMOVE, 32'sd0, 7'd0);
    offer_request(REQ_REMOVE, 32'sd0, 7'd5);
    offer_request(REQ_NOP, 32'sh5a5aa5a5, 7'd85);
    offer_request(REQ_RUN, 32'sd0, 7'd0);
    offer_request(REQ_CLEAR, 32'sd0, 7'd0);
    offer_request(REQ_RUN, 32'sd0, 7'd0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        tx_idle_pct = 52;
        rx_idle_pct = 8;
        hold_go     = 1'b1;
      end
      if (n == 2 * N_RANDOM / 3) begin
        drain_results();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      mode = (n / 100) % 3;
      roll = $urandom_range(99, 0);
      case (mode)
        0: kind = roll < 35 ? REQ_APPEND : roll < 70 ? REQ_INSERT : roll < 75 ? REQ_REMOVE :
                  roll < 80 ? REQ_REPLACE : roll < 88 ? REQ_READ : roll < 96 ? REQ_RUN :
                  roll < 97 ? REQ_CLEAR : REQ_NOP;
        1: kind = roll < 15 ? REQ_APPEND : roll < 30 ? REQ_INSERT : roll < 45 ? REQ_REMOVE :
                  roll < 60 ? REQ_REPLACE : roll < 78 ? REQ_READ : roll < 93 ? REQ_RUN :
                  roll < 95 ? REQ_CLEAR : REQ_NOP;
        default: kind = roll < 5 ? REQ_APPEND : roll < 10 ? REQ_INSERT : roll < 60 ? REQ_REMOVE :
                  roll < 70 ? REQ_REPLACE : roll < 85 ? REQ_READ : roll < 95 ? REQ_RUN :
                  roll < 97 ? REQ_CLEAR : REQ_NOP;
      endcase
      roll = $urandom_range(99, 0);
      if (roll < 50) val = $signed($urandom_range(3, 0)) - 1;
      else if (roll < 55) val = 32'sh7fffffff;
      else if (roll < 60) val = 32'sh80000000;
      else val = $urandom();
      if ($urandom_range(99, 0) < 15) pos = POS_W'($urandom_range(127, 0));
      else if (kind == REQ_INSERT) pos = POS_W'($urandom_range(shadow_len, 0));
      else if (shadow_len == 0) pos = '0;
      else pos = POS_W'($urandom_range(shadow_len - 1, 0));
      offer_request(kind, val, pos);
    end

    drain_results();
    repeat (2 * CAPACITY + 8) @(posedge clk_i);

    $display("Covered %0d random and 25 directed words: append %0d insert %0d remove %0d",
             N_RANDOM, sent_by_kind[REQ_APPEND], sent_by_kind[REQ_INSERT],
             sent_by_kind[REQ_REMOVE]);
    $display("replace %0d read %0d clear %0d run %0d nop %0d, peak length %0d, %0d adds on full",
             sent_by_kind[REQ_REPLACE], sent_by_kind[REQ_READ], sent_by_kind[REQ_CLEAR],
             sent_by_kind[REQ_RUN], sent_by_kind[REQ_NOP], peak_len, full_adds);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/plrq_pkg.sv
hdl/plrq_cell.sv
hdl/plrq_ctrl.sv
hdl/positional_list_with_run_query.sv
bench/plrq_checker.sv
bench/testbench.sv
